// ----- sv/bel_pkg.sv -----
package bel_pkg;

  localparam int unsigned ChWidth = 8;

  localparam logic [ChWidth-1:0] CH_STAR  = 8'h2A;
  localparam logic [ChWidth-1:0] CH_LT    = 8'h3C;
  localparam logic [ChWidth-1:0] CH_GT    = 8'h3E;
  localparam logic [ChWidth-1:0] CH_EQ    = 8'h3D;
  localparam logic [ChWidth-1:0] CH_SPACE = 8'h20;
  localparam logic [ChWidth-1:0] CH_TAB   = 8'h09;
  localparam logic [ChWidth-1:0] CH_CR    = 8'h0D;
  localparam logic [ChWidth-1:0] CH_ZERO  = 8'h30;
  localparam logic [ChWidth-1:0] CH_NINE  = 8'h39;
  localparam logic [ChWidth-1:0] CH_UPP_A = 8'h41;
  localparam logic [ChWidth-1:0] CH_UPP_Z = 8'h5A;
  localparam logic [ChWidth-1:0] CH_LOW_A = 8'h61;
  localparam logic [ChWidth-1:0] CH_LOW_Z = 8'h7A;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_NUM   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_OP    = 4'b1000
  } scan_mode_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_STAR = 2'd1,
    PEND_LT   = 2'd2,
    PEND_GT   = 2'd3
  } pend_op_t;

  typedef enum logic [1:0] {
    KIND_BLANK  = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_IDENT  = 2'd2,
    KIND_OPER   = 2'd3
  } kind_t;

  typedef struct packed {
    scan_mode_t mode;
    pend_op_t   pend;
  } scan_state_t;

  typedef struct packed {
    logic [ChWidth-1:0] ch;
    kind_t              kind;
    logic               starts_token;
    logic               line_done;
  } result_t;

endpackage

// ----- sv/bel_in_if.sv -----
interface bel_in_if;
  import bel_pkg::*;

  logic               valid;
  logic               ready;
  logic [ChWidth-1:0] ch;
  logic               end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink (input valid, input ch, input end_of_line, output ready);

endinterface

// ----- sv/bel_out_if.sv -----
interface bel_out_if;
  import bel_pkg::*;

  logic               valid;
  logic               ready;
  logic [ChWidth-1:0] out_ch;
  logic [1:0]         kind;
  logic               starts_token;
  logic               line_done;

  modport source (output valid, output out_ch, output kind, output starts_token,
                  output line_done, input ready);
  modport sink (input valid, input out_ch, input kind, input starts_token,
                input line_done, output ready);

endinterface

// ----- sv/basic_expression_lexer.sv -----
// Channel  Direction  Handshake     Payload
// item     in         valid/ready   ch[7:0], end_of_line
// result   out        valid/ready   out_ch[7:0], kind[1:0], starts_token, line_done
//
// One byte per cycle sustained while the result is not stalled; each beat is held in
// the input register and then moves to the result register, from which it leaves
// once the result is taken.
// The scan state advances when a beat moves from the input register to the result
// register, which bounds the rate to one byte per cycle.
// Synchronous reset clears the valid flags and the scan state.
// A stalled result holds both registers; ready to the input drops only when both are full.
module basic_expression_lexer
  import bel_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bel_in_if.sink    item,
  bel_out_if.source result
);

  logic               s1_valid;
  logic [ChWidth-1:0] s1_ch;
  logic               s1_eol;
  logic               o_valid;
  result_t            o_data;
  scan_state_t        state;
  scan_state_t        state_next;
  result_t            res;
  logic               advance;

  assign advance    = s1_valid && (!o_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  bel_classify u_classify (
    .ch          (s1_ch),
    .end_of_line (s1_eol),
    .state       (state),
    .res         (res),
    .state_next  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.ready && item.valid) begin
      s1_ch  <= item.ch;
      s1_eol <= item.end_of_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      state.mode <= MODE_IDLE;
      state.pend <= PEND_NONE;
    end else if (advance) begin
      o_valid <= 1'b1;
      state   <= state_next;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
    if (advance) begin
      o_data <= res;
    end
  end

  assign result.valid        = o_valid;
  assign result.out_ch       = o_data.ch;
  assign result.kind         = o_data.kind;
  assign result.starts_token = o_data.starts_token;
  assign result.line_done    = o_data.line_done;

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s1_eol |=> state.mode == MODE_IDLE && state.pend == PEND_NONE)
    else $error("scan state not cleared after end of line");

  a_pend_in_op: assert property (@(posedge clk) disable iff (rst)
    state.pend != PEND_NONE |-> state.mode == MODE_OP)
    else $error("pending operator outside operator mode");

  a_blank_no_start: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_data.kind == KIND_BLANK |-> !o_data.starts_token)
    else $error("whitespace marked as token start");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> s1_valid && o_valid && !result.ready)
    else $error("input stalled while a stage is free");

endmodule

// ----- sv/bel_classify.sv -----
module bel_classify
  import bel_pkg::*;
(
  input  logic [ChWidth-1:0] ch,
  input  logic               end_of_line,
  input  scan_state_t        state,
  output result_t            res,
  output scan_state_t        state_next
);

  logic is_blank;
  logic is_digit;
  logic is_letter;
  logic joins;

  always_comb begin
    is_blank  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_letter = (ch >= CH_UPP_A && ch <= CH_UPP_Z) || (ch >= CH_LOW_A && ch <= CH_LOW_Z);
    unique case (state.pend)
      PEND_STAR:         joins = (ch == CH_STAR);
      PEND_LT, PEND_GT:  joins = (ch == CH_EQ);
      default:           joins = 1'b0;
    endcase
  end

  always_comb begin
    res.ch        = ch;
    res.line_done = end_of_line;
    state_next    = state;
    priority if (state.mode == MODE_OP && joins) begin
      res.kind          = KIND_OPER;
      res.starts_token  = 1'b0;
      state_next.mode   = MODE_IDLE;
      state_next.pend   = PEND_NONE;
    end else if (is_blank) begin
      res.kind          = KIND_BLANK;
      res.starts_token  = 1'b0;
      state_next.mode   = MODE_IDLE;
      state_next.pend   = PEND_NONE;
    end else if (is_digit) begin
      state_next.pend   = PEND_NONE;
      if (state.mode == MODE_IDENT) begin
        res.kind         = KIND_IDENT;
        res.starts_token = 1'b0;
      end else begin
        res.kind         = KIND_NUMBER;
        res.starts_token = (state.mode != MODE_NUM);
        state_next.mode  = MODE_NUM;
      end
    end else if (is_letter) begin
      state_next.pend   = PEND_NONE;
      res.kind          = KIND_IDENT;
      res.starts_token  = (state.mode != MODE_IDENT);
      state_next.mode   = MODE_IDENT;
    end else begin
      res.kind          = KIND_OPER;
      res.starts_token  = 1'b1;
      state_next.mode   = MODE_OP;
      priority if (ch == CH_STAR) begin
        state_next.pend = PEND_STAR;
      end else if (ch == CH_LT) begin
        state_next.pend = PEND_LT;
      end else if (ch == CH_GT) begin
        state_next.pend = PEND_GT;
      end else begin
        state_next.pend = PEND_NONE;
      end
    end

    // A line never pairs operators or continues tokens into the next one.
    if (end_of_line) begin
      state_next.mode = MODE_IDLE;
      state_next.pend = PEND_NONE;
    end
  end

endmodule

// ----- bench/basic_expression_lexer_test.sv -----
module basic_expression_lexer_test;
  import bel_pkg::*;

  localparam int RandomItems = 1450;
  localparam int IdleLimit   = 400;
  localparam int PrintLimit  = 40;

  typedef struct packed {
    logic [ChWidth-1:0] ch;
    logic               eol;
  } lex_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bel_in_if  item_if ();
  bel_out_if result_if ();

  basic_expression_lexer u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lex_beat_t  pending_beats[$];
  result_t    expected_tokens[$];
  scan_mode_t lex_mode = MODE_IDLE;
  pend_op_t   lex_pend = PEND_NONE;

  lex_beat_t  next_beat;
  result_t    want;
  result_t    got;
  logic       in_taken  = 1'b0;
  logic       out_taken = 1'b0;
  int         send_gap   = 0;
  int         recv_stall = 0;
  int         sent_count = 0;
  int         recv_count = 0;
  int         idle_cycles = 0;
  int         mismatch_count = 0;

  function automatic logic is_blank(input logic [ChWidth-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [ChWidth-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_letter(input logic [ChWidth-1:0] c);
    return (c >= CH_UPP_A && c <= CH_UPP_Z) || (c >= CH_LOW_A && c <= CH_LOW_Z);
  endfunction

  function automatic logic pend_joins(input pend_op_t p, input logic [ChWidth-1:0] c);
    case (p)
      PEND_STAR: return c == CH_STAR;
      PEND_LT, PEND_GT: return c == CH_EQ;
      default: return 1'b0;
    endcase
  endfunction

  function automatic result_t lex_byte(input logic [ChWidth-1:0] c, input logic eol);
    result_t r;
    r.ch = c;
    r.line_done = eol;
    if (lex_mode == MODE_OP && pend_joins(lex_pend, c)) begin
      r.kind = KIND_OPER;
      r.starts_token = 1'b0;
      lex_mode = MODE_IDLE;
      lex_pend = PEND_NONE;
    end else if (is_blank(c)) begin
      r.kind = KIND_BLANK;
      r.starts_token = 1'b0;
      lex_mode = MODE_IDLE;
      lex_pend = PEND_NONE;
    end else if (is_digit(c)) begin
      lex_pend = PEND_NONE;
      if (lex_mode == MODE_IDENT) begin
        r.kind = KIND_IDENT;
        r.starts_token = 1'b0;
      end else begin
        r.kind = KIND_NUMBER;
        r.starts_token = (lex_mode != MODE_NUM);
        lex_mode = MODE_NUM;
      end
    end else if (is_letter(c)) begin
      lex_pend = PEND_NONE;
      r.kind = KIND_IDENT;
      r.starts_token = (lex_mode != MODE_IDENT);
      lex_mode = MODE_IDENT;
    end else begin
      r.kind = KIND_OPER;
      r.starts_token = 1'b1;
      lex_mode = MODE_OP;
      if (c == CH_STAR) lex_pend = PEND_STAR;
      else if (c == CH_LT) lex_pend = PEND_LT;
      else if (c == CH_GT) lex_pend = PEND_GT;
      else lex_pend = PEND_NONE;
    end
    if (eol) begin
      lex_mode = MODE_IDLE;
      lex_pend = PEND_NONE;
    end
    return r;
  endfunction

  function automatic int draw_wait(input int count, input int period, input int phase);
    if ((count / period) % 4 == phase) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [ChWidth-1:0] random_letter();
    if ($urandom_range(0, 1)) return ChWidth'(CH_UPP_A + $urandom_range(0, 25));
    return ChWidth'(CH_LOW_A + $urandom_range(0, 25));
  endfunction

  function automatic logic [ChWidth-1:0] random_digit();
    return ChWidth'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [ChWidth-1:0] random_blank();
    int r;
    r = $urandom_range(0, 6);
    return (r > 4) ? CH_SPACE : ChWidth'(CH_TAB + r);
  endfunction

  function automatic logic [ChWidth-1:0] random_other();
    logic [ChWidth-1:0] c;
    do c = ChWidth'($urandom_range(0, 255));
    while (is_blank(c) || is_digit(c) || is_letter(c));
    return c;
  endfunction

  task automatic push_byte(input logic [ChWidth-1:0] c, input logic eol);
    lex_beat_t b;
    b.ch = c;
    b.eol = eol;
    pending_beats = {pending_beats, b};
  endtask

  task automatic add_text(input string s, input logic eol_at_end);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], eol_at_end && i == s.len() - 1);
  endtask

  task automatic add_random_line();
    logic [ChWidth-1:0] text_bytes[$];
    int n_tokens;
    int len;
    n_tokens = $urandom_range(1, 14);
    for (int t = 0; t < n_tokens; t++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) text_bytes = {text_bytes, random_digit()};
        end
        2, 3: begin
          len = $urandom_range(0, 5);
          text_bytes = {text_bytes, random_letter()};
          for (int i = 0; i < len; i++)
            text_bytes = {text_bytes,
                          ($urandom_range(0, 2) == 0) ? random_digit() : random_letter()};
        end
        4, 5: begin
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++) text_bytes = {text_bytes, random_blank()};
        end
        6: begin
          case ($urandom_range(0, 2))
            0: text_bytes = {text_bytes, CH_STAR, CH_STAR};
            1: text_bytes = {text_bytes, CH_LT, CH_EQ};
            default: text_bytes = {text_bytes, CH_GT, CH_EQ};
          endcase
        end
        7: begin
          case ($urandom_range(0, 3))
            0: text_bytes = {text_bytes, CH_STAR};
            1: text_bytes = {text_bytes, CH_LT};
            2: text_bytes = {text_bytes, CH_GT};
            default: text_bytes = {text_bytes, CH_EQ};
          endcase
        end
        8: text_bytes = {text_bytes, random_other()};
        default: text_bytes = {text_bytes, ChWidth'($urandom_range(0, 255))};
      endcase
    end
    foreach (text_bytes[i]) push_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  task automatic report_mismatch(input string what, input int got_val, input int want_val);
    if (mismatch_count < PrintLimit)
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               recv_count, what, got_val, want_val);
    mismatch_count++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else if (item_if.valid && !in_taken) begin
    end else if (send_gap > 0) begin
      item_if.valid <= 1'b0;
      send_gap--;
    end else if (pending_beats.size() > 0) begin
      next_beat = pending_beats.pop_front();
      item_if.ch <= next_beat.ch;
      item_if.end_of_line <= next_beat.eol;
      item_if.valid <= 1'b1;
      sent_count++;
      send_gap = draw_wait(sent_count, 64, 1);
    end else begin
      item_if.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) recv_stall = draw_wait(recv_count, 80, 2);
      if (recv_stall > 0) begin
        result_if.ready <= 1'b0;
        recv_stall--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= item_if.valid && item_if.ready;
    out_taken <= result_if.valid && result_if.ready;
    if (!rst) begin
      if (item_if.valid && item_if.ready)
        expected_tokens = {expected_tokens, lex_byte(item_if.ch, item_if.end_of_line)};
      if (result_if.valid && result_if.ready) begin
        got.ch = result_if.out_ch;
        got.kind = kind_t'(result_if.kind);
        got.starts_token = result_if.starts_token;
        got.line_done = result_if.line_done;
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected beat, byte", got.ch, 0);
        end else begin
          want = expected_tokens.pop_front();
          if (got.ch !== want.ch) report_mismatch("out_ch", got.ch, want.ch);
          if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
          if (got.starts_token !== want.starts_token)
            report_mismatch("starts_token", got.starts_token, want.starts_token);
          if (got.line_done !== want.line_done)
            report_mismatch("line_done", got.line_done, want.line_done);
        end
        recv_count++;
      end
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("basic_expression_lexer_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    item_if.valid = 1'b0;
    item_if.ch = '0;
    item_if.end_of_line = 1'b0;
    result_if.ready = 1'b0;

    add_text("***<=>=", 1'b0);
    add_text("x9 42a", 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(ChWidth'(CH_TAB - 1), 1'b0);
    push_byte(ChWidth'(CH_CR + 1), 1'b0);
    push_byte(CH_STAR, 1'b1);
    push_byte(CH_STAR, 1'b0);
    add_text("<>", 1'b1);
    len_loop: while (pending_beats.size() < 25 + RandomItems) add_random_line();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_beats.size() != 0 || item_if.valid || expected_tokens.size() != 0);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("basic_expression_lexer_test OK");
    end else begin
      $display("basic_expression_lexer_test NOT OK");
    end
    $finish;
  end

endmodule
